>>> rtl/core/cme_pkg.sv
// Shared constants, state and command types for the correlation matrix engine.
// No dependencies; cme_iter, the engine and the testbench import this package.
package cme_pkg;

    localparam int MAX_ASSETS       = 8;
    localparam int MAX_OBSERVATIONS = 1024;
    localparam int ASSET_W          = $clog2(MAX_ASSETS);
    localparam int OBS_W            = $clog2(MAX_OBSERVATIONS);
    localparam int STORE_DEPTH      = MAX_ASSETS * MAX_OBSERVATIONS;
    localparam int ADDR_W           = ASSET_W + OBS_W;
    localparam int NCNT_W           = OBS_W + 1;
    localparam int ACNT_W           = ASSET_W + 1;

    localparam int SAMPLE_W = 16;
    localparam int SUM_W    = 26;
    localparam int ACC_W    = 42;
    localparam int COV_W    = 56;
    localparam int MAG_W    = 55;
    localparam int QV_W     = 64;
    localparam int OPND_W   = 128;
    localparam int CNT_W    = 7;
    localparam int CFG_W    = 11;
    localparam int QUOT_W   = 17;

    localparam int MUL_STEPS  = 64;
    localparam int ROOT_STEPS = 64;
    localparam int DIV_STEPS  = QUOT_W;

    // Configuration register indexes
    localparam logic REG_ASSET_COUNT = 1'b0;
    localparam logic REG_OBS_COUNT   = 1'b1;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_SQRT,
        OP_DIV
    } iter_op_t;

    typedef struct packed {
        logic     start;
        iter_op_t op;
    } iter_cmd_t;

    typedef struct packed {
        logic busy;
    } iter_stat_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_ACC,
        ST_SUMA,
        ST_SUMB,
        ST_COV,
        ST_QSTORE,
        ST_QROW,
        ST_QCOL,
        ST_MUL,
        ST_SQRT,
        ST_NM,
        ST_DIVS,
        ST_DIV,
        ST_OUT
    } state_t;

endpackage

>>> rtl/core/cme_ram.sv
// Generic single-write, dual-read RAM with registered read data.
// No dependencies.
module cme_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

>>> rtl/core/cme_iter.sv
// Shared iterative unit: shift-add multiply, digit-by-digit square root and
// restoring divide, one step per cycle. Depends on cme_pkg.
module cme_iter (
    input  logic                        clk,
    input  logic                        rst_n,
    input  cme_pkg::iter_cmd_t          cmd,
    input  logic [cme_pkg::OPND_W-1:0]  opnd_a,
    input  logic [cme_pkg::OPND_W-1:0]  opnd_b,
    output cme_pkg::iter_stat_t         stat,
    output logic [cme_pkg::OPND_W-1:0]  result
);

    import cme_pkg::*;

    logic             busy_reg, busy_next;
    iter_op_t         op_reg, op_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [OPND_W-1:0] x_reg, x_next;
    logic [OPND_W-1:0] y_reg, y_next;
    logic [OPND_W-1:0] z_reg, z_next;
    logic [67:0]      rem2;
    logic [67:0]      trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            op_reg   <= OP_MUL;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign rem2  = {y_reg[65:0], x_reg[OPND_W-1 -: 2]};
    assign trial = {z_reg[65:0], 2'b01};

    always_comb
    begin
        busy_next = busy_reg;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        if (cmd.start)
        begin
            busy_next = 1'b1;
            op_next   = cmd.op;
            z_next    = '0;
            unique case (cmd.op)
                OP_MUL:
                begin
                    x_next   = opnd_a;
                    y_next   = opnd_b;
                    cnt_next = CNT_W'(MUL_STEPS - 1);
                end
                OP_SQRT:
                begin
                    x_next   = opnd_a;
                    y_next   = '0;
                    cnt_next = CNT_W'(ROOT_STEPS - 1);
                end
                OP_DIV:
                begin
                    x_next   = opnd_a;
                    y_next   = opnd_b << (QUOT_W - 1);
                    cnt_next = CNT_W'(DIV_STEPS - 1);
                end
                default:
                begin
                    busy_next = 1'b0;
                end
            endcase
        end
        else if (busy_reg)
        begin
            unique case (op_reg)
                OP_MUL:
                begin
                    if (x_reg[0])
                    begin
                        z_next = z_reg + y_reg;
                    end
                    x_next = x_reg >> 1;
                    y_next = y_reg << 1;
                end
                OP_SQRT:
                begin
                    if (rem2 >= trial)
                    begin
                        y_next = OPND_W'(rem2 - trial);
                        z_next = {z_reg[OPND_W-2:0], 1'b1};
                    end
                    else
                    begin
                        y_next = OPND_W'(rem2);
                        z_next = {z_reg[OPND_W-2:0], 1'b0};
                    end
                    x_next = x_reg << 2;
                end
                OP_DIV:
                begin
                    if (x_reg >= y_reg)
                    begin
                        x_next = x_reg - y_reg;
                        z_next = {z_reg[OPND_W-2:0], 1'b1};
                    end
                    else
                    begin
                        z_next = {z_reg[OPND_W-2:0], 1'b0};
                    end
                    y_next = y_reg >> 1;
                end
                default:
                begin
                    z_next = z_reg;
                end
            endcase
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
        end
    end

    assign stat.busy = busy_reg;
    assign result    = z_reg;

endmodule

>>> rtl/core/correlation_matrix_engine_unit.sv
// Pearson correlation matrix engine: load, per-asset sums and the sequencer.
// Depends on cme_pkg, cme_ram and cme_iter.
// One sample transfer per cycle while loading and no register write lands. The
// last sample starts the compute: a variance pass per asset, then per matrix
// entry a pass over the sample store, 64-step multiply, 64-step root and
// 17-step divide in the shared unit (no divide on a zero-variance pair);
// the sequencer waits while the output is stalled. Input is held off
// until the last entry transfers, and in any cycle with a register write.
// Reset: asynchronous, active low; clears sums, counters, sequencer and
// registers to 8 assets, 1024 observations. The sample store is not cleared.
module correlation_matrix_engine_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic                               cfg_index,
    input  logic [cme_pkg::CFG_W-1:0]          cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [cme_pkg::SAMPLE_W-1:0] sample,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [cme_pkg::ASSET_W-1:0]        row_index,
    output logic [cme_pkg::ASSET_W-1:0]        column_index,
    output logic signed [cme_pkg::SAMPLE_W-1:0] coefficient,
    output logic                               last_entry
);

    import cme_pkg::*;

    // Configuration, raw bits as written
    logic [3:0]        asset_cfg_reg, asset_cfg_next;
    logic [CFG_W-1:0]  obs_cfg_reg, obs_cfg_next;
    logic [ACNT_W-1:0] na_eff;
    logic [NCNT_W-1:0] n_eff;
    logic [ASSET_W-1:0] na_m1;
    logic [OBS_W-1:0]  n_m1;

    state_t state_reg, state_next;

    // Load position
    logic [ASSET_W-1:0] la_reg, la_next;
    logic [OBS_W-1:0]   lo_reg, lo_next;

    logic signed [SUM_W-1:0] sums_reg [MAX_ASSETS];
    logic signed [SUM_W-1:0] sums_next [MAX_ASSETS];

    // Compute datapath
    logic [ASSET_W-1:0]      ia_reg, ia_next;
    logic [ASSET_W-1:0]      ib_reg, ib_next;
    logic                    pair_phase_reg, pair_phase_next;
    logic [NCNT_W-1:0]       kk_reg, kk_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [SUM_W-1:0] sa_reg, sa_next;
    logic signed [COV_W-1:0] t1_reg, t1_next;
    logic signed [COV_W-1:0] t2_reg, t2_next;
    logic signed [COV_W-1:0] cov_reg, cov_next;
    logic [QV_W-1:0]         qv_reg [MAX_ASSETS];
    logic                    qv_we;
    logic [QV_W-1:0]         qv_wdata;
    logic [QV_W-1:0]         qrow_reg, qrow_next;
    logic [QV_W-1:0]         den_reg, den_next;
    logic [81:0]             nm_reg, nm_next;

    logic                    out_valid_reg, out_valid_next;
    logic [ASSET_W-1:0]      row_reg, row_next;
    logic [ASSET_W-1:0]      col_reg, col_next;
    logic [SAMPLE_W-1:0]     coef_reg, coef_next;
    logic                    last_reg, last_next;

    // Memory and shared unit hookup
    logic                    ram_we;
    logic [ADDR_W-1:0]       ram_raddr_a, ram_raddr_b;
    logic [SAMPLE_W-1:0]     ram_rdata_a, ram_rdata_b;
    iter_cmd_t               iter_cmd;
    iter_stat_t              iter_stat;
    logic [OPND_W-1:0]       iter_a, iter_b, iter_res;

    // Scratch
    logic                    in_xfer;
    logic [ASSET_W-1:0]      sum_idx;
    logic [ASSET_W-1:0]      q_idx;
    logic signed [31:0]      prod;
    logic signed [ACC_W+NCNT_W:0] nacc_prod;
    logic signed [2*SUM_W-1:0]    sum_prod;
    logic [MAG_W-1:0]        mag;
    logic [QUOT_W-1:0]       quot;
    logic [QUOT_W-1:0]       quot_sat;
    logic                    last_pair;

    // Effective counts: saturate into the supported range
    always_comb
    begin
        if (asset_cfg_reg < 4'd2)
        begin
            na_eff = ACNT_W'(2);
        end
        else if (asset_cfg_reg > 4'(MAX_ASSETS))
        begin
            na_eff = ACNT_W'(MAX_ASSETS);
        end
        else
        begin
            na_eff = ACNT_W'(asset_cfg_reg);
        end
        if (obs_cfg_reg < CFG_W'(2))
        begin
            n_eff = NCNT_W'(2);
        end
        else if (obs_cfg_reg > CFG_W'(MAX_OBSERVATIONS))
        begin
            n_eff = NCNT_W'(MAX_OBSERVATIONS);
        end
        else
        begin
            n_eff = NCNT_W'(obs_cfg_reg);
        end
    end

    assign na_m1 = ASSET_W'(na_eff - ACNT_W'(1));
    assign n_m1  = OBS_W'(n_eff - NCNT_W'(1));

    // Hold off samples while computing and while a register write lands
    assign in_stall = (state_reg != ST_LOAD) || cfg_we;
    assign in_xfer  = in_valid && !in_stall;

    assign sum_idx = (state_reg == ST_SUMA) ? ia_reg : ib_reg;
    assign q_idx   = (state_reg == ST_QROW) ? ia_reg : ib_reg;
    assign prod    = $signed(ram_rdata_a) * $signed(ram_rdata_b);
    assign nacc_prod = $signed({1'b0, n_eff}) * acc_reg;
    assign sum_prod  = sa_reg * sums_reg[sum_idx];
    assign mag     = cov_reg[COV_W-1] ? MAG_W'(-cov_reg) : MAG_W'(cov_reg);
    assign quot    = iter_res[QUOT_W-1:0];
    assign last_pair = (ia_reg == na_m1) && (ib_reg == na_m1);

    assign ram_we      = in_xfer;
    assign ram_raddr_a = {ia_reg, kk_reg[OBS_W-1:0]};
    assign ram_raddr_b = {ib_reg, kk_reg[OBS_W-1:0]};

    cme_ram #(
        .WIDTH(SAMPLE_W),
        .DEPTH(STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .we      (ram_we),
        .waddr   ({la_reg, lo_reg}),
        .wdata   (sample),
        .raddr_a (ram_raddr_a),
        .raddr_b (ram_raddr_b),
        .rdata_a (ram_rdata_a),
        .rdata_b (ram_rdata_b)
    );

    cme_iter u_iter (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (iter_cmd),
        .opnd_a (iter_a),
        .opnd_b (iter_b),
        .stat   (iter_stat),
        .result (iter_res)
    );

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            asset_cfg_reg  <= 4'(MAX_ASSETS);
            obs_cfg_reg    <= CFG_W'(MAX_OBSERVATIONS);
            la_reg         <= '0;
            lo_reg         <= '0;
            ia_reg         <= '0;
            ib_reg         <= '0;
            pair_phase_reg <= 1'b0;
            kk_reg         <= '0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < MAX_ASSETS; i++)
            begin
                sums_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            asset_cfg_reg  <= asset_cfg_next;
            obs_cfg_reg    <= obs_cfg_next;
            la_reg         <= la_next;
            lo_reg         <= lo_next;
            ia_reg         <= ia_next;
            ib_reg         <= ib_next;
            pair_phase_reg <= pair_phase_next;
            kk_reg         <= kk_next;
            out_valid_reg  <= out_valid_next;
            for (int i = 0; i < MAX_ASSETS; i++)
            begin
                sums_reg[i] <= sums_next[i];
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        sa_reg   <= sa_next;
        t1_reg   <= t1_next;
        t2_reg   <= t2_next;
        cov_reg  <= cov_next;
        qrow_reg <= qrow_next;
        den_reg  <= den_next;
        nm_reg   <= nm_next;
        row_reg  <= row_next;
        col_reg  <= col_next;
        coef_reg <= coef_next;
        last_reg <= last_next;
        if (qv_we)
        begin
            qv_reg[ia_reg] <= qv_wdata;
        end
    end

    // Sequencer: next state and datapath control
    always_comb
    begin
        state_next      = state_reg;
        asset_cfg_next  = asset_cfg_reg;
        obs_cfg_next    = obs_cfg_reg;
        la_next         = la_reg;
        lo_next         = lo_reg;
        sums_next       = sums_reg;
        ia_next         = ia_reg;
        ib_next         = ib_reg;
        pair_phase_next = pair_phase_reg;
        kk_next         = kk_reg;
        acc_next        = acc_reg;
        sa_next         = sa_reg;
        t1_next         = t1_reg;
        t2_next         = t2_reg;
        cov_next        = cov_reg;
        qrow_next       = qrow_reg;
        den_next        = den_reg;
        nm_next         = nm_reg;
        out_valid_next  = out_valid_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        coef_next       = coef_reg;
        last_next       = last_reg;
        qv_we           = 1'b0;
        qv_wdata        = QV_W'(66'(n_eff) * 66'(cov_reg[MAG_W-1:0]));
        iter_cmd.start  = 1'b0;
        iter_cmd.op     = OP_MUL;
        iter_a          = '0;
        iter_b          = '0;
        quot_sat        = '0;

        unique case (state_reg)
            ST_LOAD:
            begin
                // Any register write restarts the load
                if (cfg_we)
                begin
                    if (cfg_index == REG_ASSET_COUNT)
                    begin
                        asset_cfg_next = cfg_data[3:0];
                    end
                    else
                    begin
                        obs_cfg_next = cfg_data;
                    end
                    la_next = '0;
                    lo_next = '0;
                    for (int i = 0; i < MAX_ASSETS; i++)
                    begin
                        sums_next[i] = '0;
                    end
                end
                else if (in_xfer)
                begin
                    sums_next[la_reg] = sums_reg[la_reg] + SUM_W'(sample);
                    if (lo_reg == n_m1)
                    begin
                        lo_next = '0;
                        if (la_reg == na_m1)
                        begin
                            // Last sample: start the variance pass on asset 0
                            la_next         = '0;
                            ia_next         = '0;
                            ib_next         = '0;
                            pair_phase_next = 1'b0;
                            kk_next         = '0;
                            acc_next        = '0;
                            state_next      = ST_ACC;
                        end
                        else
                        begin
                            la_next = la_reg + ASSET_W'(1);
                        end
                    end
                    else
                    begin
                        lo_next = lo_reg + OBS_W'(1);
                    end
                end
            end
            ST_ACC:
            begin
                // Read data is registered and follows its address in the next cycle
                if (kk_reg != '0)
                begin
                    acc_next = acc_reg + ACC_W'(prod);
                end
                kk_next = kk_reg + NCNT_W'(1);
                if (kk_reg == n_eff)
                begin
                    state_next = ST_SUMA;
                end
            end
            ST_SUMA:
            begin
                sa_next    = sums_reg[sum_idx];
                state_next = ST_SUMB;
            end
            ST_SUMB:
            begin
                t1_next    = COV_W'(nacc_prod);
                t2_next    = COV_W'(sum_prod);
                state_next = ST_COV;
            end
            ST_COV:
            begin
                cov_next   = t1_reg - t2_reg;
                state_next = pair_phase_reg ? ST_QROW : ST_QSTORE;
            end
            ST_QSTORE:
            begin
                // Hold n times the reduced variance, floored at zero
                qv_we = 1'b1;
                if (cov_reg[COV_W-1])
                begin
                    qv_wdata = '0;
                end
                kk_next  = '0;
                acc_next = '0;
                if (ia_reg == na_m1)
                begin
                    ia_next         = '0;
                    ib_next         = '0;
                    pair_phase_next = 1'b1;
                end
                else
                begin
                    ia_next = ia_reg + ASSET_W'(1);
                    ib_next = ib_reg + ASSET_W'(1);
                end
                state_next = ST_ACC;
            end
            ST_QROW:
            begin
                qrow_next  = qv_reg[q_idx];
                state_next = ST_QCOL;
            end
            ST_QCOL:
            begin
                iter_cmd.start = 1'b1;
                iter_cmd.op    = OP_MUL;
                iter_a         = OPND_W'(qrow_reg);
                iter_b         = OPND_W'(qv_reg[q_idx]);
                state_next     = ST_MUL;
            end
            ST_MUL:
            begin
                if (!iter_stat.busy)
                begin
                    iter_cmd.start = 1'b1;
                    iter_cmd.op    = OP_SQRT;
                    iter_a         = iter_res;
                    state_next     = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                if (!iter_stat.busy)
                begin
                    den_next = iter_res[QV_W-1:0];
                    if (iter_res == '0)
                    begin
                        // Zero variance on either side
                        coef_next      = '0;
                        row_next       = ia_reg;
                        col_next       = ib_reg;
                        last_next      = last_pair;
                        out_valid_next = 1'b1;
                        state_next     = ST_OUT;
                    end
                    else
                    begin
                        state_next = ST_NM;
                    end
                end
            end
            ST_NM:
            begin
                nm_next    = 82'(66'(n_eff) * 66'(mag)) << 16;
                state_next = ST_DIVS;
            end
            ST_DIVS:
            begin
                iter_cmd.start = 1'b1;
                iter_cmd.op    = OP_DIV;
                iter_a         = OPND_W'(nm_reg + 82'(den_reg));
                iter_b         = OPND_W'({den_reg, 1'b0});
                state_next     = ST_DIV;
            end
            ST_DIV:
            begin
                if (!iter_stat.busy)
                begin
                    if (cov_reg[COV_W-1])
                    begin
                        quot_sat  = (quot > QUOT_W'(32768)) ? QUOT_W'(32768) : quot;
                        coef_next = SAMPLE_W'(QUOT_W'(0) - quot_sat);
                    end
                    else
                    begin
                        quot_sat  = (quot > QUOT_W'(32767)) ? QUOT_W'(32767) : quot;
                        coef_next = SAMPLE_W'(quot_sat);
                    end
                    row_next       = ia_reg;
                    col_next       = ib_reg;
                    last_next      = last_pair;
                    out_valid_next = 1'b1;
                    state_next     = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_valid_reg && !out_stall)
                begin
                    out_valid_next = 1'b0;
                    kk_next        = '0;
                    acc_next       = '0;
                    if (ib_reg != na_m1)
                    begin
                        ib_next    = ib_reg + ASSET_W'(1);
                        state_next = ST_ACC;
                    end
                    else if (ia_reg != na_m1)
                    begin
                        ia_next    = ia_reg + ASSET_W'(1);
                        ib_next    = '0;
                        state_next = ST_ACC;
                    end
                    else
                    begin
                        // Run complete: drop the sums, restart the load
                        la_next = '0;
                        lo_next = '0;
                        for (int i = 0; i < MAX_ASSETS; i++)
                        begin
                            sums_next[i] = '0;
                        end
                        state_next = ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign row_index    = row_reg;
    assign column_index = col_reg;
    assign coefficient  = coef_reg;
    assign last_entry   = last_reg;

endmodule

>>> tb/correlation_matrix_engine_unit_tb.sv
// Self-checking testbench for the correlation matrix engine: loads data sets,
// predicts every matrix entry with exact integer arithmetic and checks them.
// Depends on cme_pkg and correlation_matrix_engine_unit.
`timescale 1ns / 1ps

module correlation_matrix_engine_unit_tb;
    import cme_pkg::*;

    localparam longint CYCLE_LIMIT = 3000000;
    localparam int     RANDOM_ITEMS = 270;

    typedef enum logic { ROW_CFG, ROW_SAMPLE } row_kind_t;

    // One directed row: a register write or a sample transfer. Where typed is
    // set, the matrix that this sample completes is read off by hand.
    typedef struct packed {
        row_kind_t   kind;
        logic        index;
        logic [15:0] value;
        logic        typed;
        logic [15:0] diag_coef;
        logic [15:0] off_coef;
    } stim_row_t;

    typedef struct packed {
        logic [2:0]  row;
        logic [2:0]  col;
        logic [15:0] coef;
        logic        last;
    } entry_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic                cfg_index;
    logic [CFG_W-1:0]    cfg_data;
    logic                in_valid;
    logic                in_stall;
    logic signed [15:0]  sample;
    logic                out_valid;
    logic                out_stall;
    logic [ASSET_W-1:0]  row_index;
    logic [ASSET_W-1:0]  column_index;
    logic signed [15:0]  coefficient;
    logic                last_entry;

    correlation_matrix_engine_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample       (sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .row_index    (row_index),
        .column_index (column_index),
        .coefficient  (coefficient),
        .last_entry   (last_entry)
    );

    // Shadow of the block: sample memory, per-asset sums, load position and
    // the raw register bits as written.
    logic signed [15:0] shadow_store [STORE_DEPTH];
    longint             shadow_sums  [MAX_ASSETS];
    int                 shadow_pos;
    logic [3:0]         shadow_assets;
    logic [10:0]        shadow_obs;

    entry_t             pending_entries [$];
    int                 mismatches;
    longint             cycles;
    int                 idle_pct;
    int                 stall_pct;
    int                 base_series [MAX_OBSERVATIONS];

    stim_row_t          plan [24];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Guard the whole run against a hang.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("correlation_matrix_engine_unit regression: fail");
            $finish;
        end
    end

    // Receiver: stall at random, check each result transfer against the
    // oldest pending entry. Values read here are those before the edge.
    always @(posedge clk)
    begin
        entry_t want;
        out_stall <= ($urandom_range(99) < stall_pct);
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_entries.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected entry (%0d,%0d) coef %0d", row_index,
                             column_index, coefficient);
                mismatches++;
            end
            else
            begin
                want = pending_entries.pop_front();
                if (want.row !== row_index || want.col !== column_index ||
                    want.coef !== coefficient || want.last !== last_entry)
                begin
                    if (mismatches < 10)
                        $display({"entry mismatch: expected (%0d,%0d) %0d last %0d,",
                                  " got (%0d,%0d) %0d last %0d"},
                                 want.row, want.col, $signed(want.coef), want.last,
                                 row_index, column_index, coefficient, last_entry);
                    mismatches++;
                end
            end
        end
    end

    function automatic int used_assets();
        if (shadow_assets < 2) return 2;
        if (shadow_assets > MAX_ASSETS) return MAX_ASSETS;
        return shadow_assets;
    endfunction

    function automatic int used_obs();
        if (shadow_obs < 2) return 2;
        if (shadow_obs > MAX_OBSERVATIONS) return MAX_OBSERVATIONS;
        return shadow_obs;
    endfunction

    function automatic void restart_shadow();
        foreach (shadow_sums[i]) shadow_sums[i] = 0;
        shadow_pos = 0;
    endfunction

    // n * sum(x_a x_b) - S_a S_b; this is n times the exact centred sum.
    function automatic longint scaled_covariance(int a, int b, int n);
        longint acc;
        acc = 0;
        for (int k = 0; k < n; k++)
            acc += longint'(shadow_store[a * MAX_OBSERVATIONS + k]) *
                   longint'(shadow_store[b * MAX_OBSERVATIONS + k]);
        return longint'(n) * acc - shadow_sums[a] * shadow_sums[b];
    endfunction

    function automatic logic [15:0] pearson_q15(int r, int c, int n);
        longint       cov_rc, var_r, var_c;
        logic [191:0] q_r, q_c, prod, root, trial, mag, num, quot;
        cov_rc = scaled_covariance(r, c, n);
        var_r  = scaled_covariance(r, r, n);
        var_c  = scaled_covariance(c, c, n);
        q_r  = 192'(n) * 192'(var_r < 0 ? 64'd0 : var_r);
        q_c  = 192'(n) * 192'(var_c < 0 ? 64'd0 : var_c);
        prod = q_r * q_c;
        root = '0;
        // floor square root, one bit at a time from the top
        for (int b = 80; b >= 0; b--)
        begin
            trial = root | (192'(1) << b);
            if (trial * trial <= prod)
                root = trial;
        end
        if (root == 0)
            return 16'd0;
        mag  = 192'(cov_rc < 0 ? -cov_rc : cov_rc);
        num  = mag * 192'(n) * 192'(65536) + root;
        quot = num / (root + root);
        if (cov_rc < 0)
        begin
            if (quot > 32768) quot = 32768;
            return -quot[15:0];
        end
        if (quot > 32767) quot = 32767;
        return quot[15:0];
    endfunction

    // Advance the shadow by one accepted sample; queue the matrix it completes.
    function automatic void predict_sample(logic [15:0] value, logic typed,
                                           logic [15:0] diag_coef, logic [15:0] off_coef);
        int     na, n, asset, obs;
        entry_t e;
        na = used_assets();
        n  = used_obs();
        if (shadow_pos >= na * n)
            restart_shadow();
        asset = shadow_pos / n;
        obs   = shadow_pos % n;
        shadow_store[asset * MAX_OBSERVATIONS + obs] = value;
        shadow_sums[asset] += longint'($signed(value));
        shadow_pos++;
        if (shadow_pos < na * n)
            return;
        for (int r = 0; r < na; r++)
            for (int c = 0; c < na; c++)
            begin
                e.row  = r[2:0];
                e.col  = c[2:0];
                e.coef = typed ? ((r == c) ? diag_coef : off_coef) : pearson_q15(r, c, n);
                e.last = (r == na - 1) && (c == na - 1);
                pending_entries.push_back(e);
            end
        restart_shadow();
    endfunction

    // Write a register once the block has drained; a write restarts the load.
    // Drop the last offered sample first so it is not taken again.
    task automatic write_register(logic index, logic [10:0] value);
        in_valid <= 1'b0;
        while (pending_entries.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (index == REG_ASSET_COUNT)
            shadow_assets = value[3:0];
        else
            shadow_obs = value;
        restart_shadow();
    endtask

    // Offer one sample, hold it through any stall, predict once it transfers.
    task automatic send_sample(logic [15:0] value, logic typed = 1'b0,
                               logic [15:0] diag_coef = '0, logic [15:0] off_coef = '0);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= value;
        do
            @(posedge clk);
        while (in_stall);
        predict_sample(value, typed, diag_coef, off_coef);
    endtask

    // Sample content for a random set: one of related series, noise,
    // flat series and rail values.
    function automatic logic [15:0] pick_sample(int mode, int k, int asset);
        case (mode)
            0: return 16'($urandom);
            1: return 16'(base_series[k] * ((asset % 2) ? -1 : 1) +
                          $signed($urandom_range(255)) - 128);
            2: return 16'(asset * 1000 - 3000);
            default: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
        endcase
    endfunction

    initial
    begin
        int done_items, set_no, na, n, mode, cut;
        logic [3:0]  asset_reg;
        logic [10:0] obs_reg;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_ASSET_COUNT;
        cfg_data = '0;
        in_valid = 1'b0;
        sample = '0;
        out_stall = 1'b0;
        cycles = 0;
        mismatches = 0;
        idle_pct = 0;
        stall_pct = 0;
        shadow_assets = 4'd8;
        shadow_obs = 11'd1024;
        restart_shadow();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: both registers below range, sample rails, full positive
        // and negative correlation, zero variance, a load cut short by a write.
        plan = '{
            '{ROW_CFG,    REG_ASSET_COUNT, 16'd0,     1'b0, 16'd0,     16'd0},
            '{ROW_CFG,    REG_OBS_COUNT,   16'd0,     1'b0, 16'd0,     16'd0},
            '{ROW_SAMPLE, 1'b0,            16'h7FFF,  1'b0, 16'd0,     16'd0},
            '{ROW_SAMPLE, 1'b0,            16'h8000,  1'b0, 16'd0,     16'd0},
            '{ROW_SAMPLE, 1'b0,            16'h7FFF,  1'b0, 16'd0,     16'd0},
            '{ROW_SAMPLE, 1'b0,            16'h8000,  1'b1, 16'h7FFF,  16'h7FFF},
            '{ROW_SAMPLE, 1'b0,            16'h8000,  1'b0, 16'd0,     16'd0},
            '{ROW_SAMPLE, 1'b0,            16'h7FFF,  1'b0, 16'd0,     16'd0},
            '{ROW_SAMPLE, 1'b0,            16'h7FFF,  1'b0, 16'd0,     16'd0},
            '{ROW_SAMPLE, 1'b0,            16'h8000,  1'b1, 16'h7FFF,  16'h8000},
            '{ROW_SAMPLE, 1'b0,            16'd0,     1'b0, 16'd0,     16'd0},
            '{ROW_SAMPLE, 1'b0,            16'd0,     1'b0, 16'd0,     16'd0},
            '{ROW_SAMPLE, 1'b0,            16'd0,     1'b0, 16'd0,     16'd0},
            '{ROW_SAMPLE, 1'b0,            16'd0,     1'b1, 16'd0,     16'd0},
            '{ROW_SAMPLE, 1'b0,            16'd1,     1'b0, 16'd0,     16'd0},
            '{ROW_SAMPLE, 1'b0,            16'd3,     1'b0, 16'd0,     16'd0},
            '{ROW_CFG,    REG_OBS_COUNT,   16'd3,     1'b0, 16'd0,     16'd0},
            '{ROW_SAMPLE, 1'b0,            16'd100,   1'b0, 16'd0,     16'd0},
            '{ROW_SAMPLE, 1'b0,            16'd200,   1'b0, 16'd0,     16'd0},
            '{ROW_SAMPLE, 1'b0,            16'hFF00,  1'b0, 16'd0,     16'd0},
            '{ROW_SAMPLE, 1'b0,            16'd7,     1'b0, 16'd0,     16'd0},
            '{ROW_SAMPLE, 1'b0,            16'd7,     1'b0, 16'd0,     16'd0},
            '{ROW_SAMPLE, 1'b0,            16'd7,     1'b0, 16'd0,     16'd0},
            '{ROW_CFG,    REG_OBS_COUNT,   16'd1,     1'b0, 16'd0,     16'd0}
        };
        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
                write_register(plan[i].index, plan[i].value[10:0]);
            else
                send_sample(plan[i].value, plan[i].typed, plan[i].diag_coef,
                            plan[i].off_coef);
        end

        // Random data sets, cycling through the idling phases.
        done_items = 0;
        set_no = 0;
        while (done_items < RANDOM_ITEMS)
        begin
            case (set_no % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 87; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 87; end
                default: begin idle_pct = 18; stall_pct = 18; end
            endcase
            // Mostly small shapes; the larger ones a few times only.
            if (set_no == 2)
            begin
                asset_reg = 4'd15;
                obs_reg = 11'd2;
            end
            else if (set_no == 5)
            begin
                asset_reg = 4'd2;
                obs_reg = 11'd40;
            end
            else if (set_no == 7)
            begin
                asset_reg = 4'd8;
                obs_reg = 11'd5;
            end
            else
            begin
                asset_reg = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) :
                                                       4'($urandom_range(2, 4));
                obs_reg = ($urandom_range(9) == 0) ? 11'($urandom_range(1)) :
                                                     11'($urandom_range(2, 6));
            end
            write_register(REG_ASSET_COUNT, {7'd0, asset_reg});
            write_register(REG_OBS_COUNT, obs_reg);
            na = used_assets();
            n = used_obs();
            mode = $urandom_range(3);
            for (int k = 0; k < n; k++)
                base_series[k] = $urandom_range(40000) - 20000;
            // A tenth of the sets are broken off part way by a register write.
            cut = ($urandom_range(9) == 0) ? $urandom_range(na * n - 1) : na * n;
            for (int p = 0; p < cut; p++)
                send_sample(pick_sample(($urandom_range(7) == 0) ? 0 : mode, p % n, p / n));
            done_items += cut;
            set_no++;
        end
        in_valid <= 1'b0;

        while (pending_entries.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        if (mismatches == 0)
            $display("correlation_matrix_engine_unit regression: pass");
        else
            $display("correlation_matrix_engine_unit regression: fail");
        $finish;
    end

endmodule
